// ===== src/sdcbr_pkg.sv =====
`default_nettype none

package sdcbr_pkg;

	localparam int BLOCK_BYTES = 512;
	localparam int DC_W        = $clog2(BLOCK_BYTES + 1);
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 9;

	localparam logic [CFG_IDX_W-1:0] REG_POLL_LIMIT  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_TOKEN_LIMIT = CFG_IDX_W'(1);

	localparam logic [8:0] POLL_LIMIT_RESET  = 9'd256;
	localparam logic [8:0] POLL_LIMIT_MAX    = 9'd256;
	localparam logic [7:0] TOKEN_LIMIT_RESET = 8'd10;

	localparam logic [7:0] CMD_PREFIX  = 8'h40;
	localparam logic [7:0] CRC_CMD0    = 8'h95;
	localparam logic [7:0] CRC_CMD8    = 8'h87;
	localparam logic [7:0] FILL_BYTE   = 8'hFF;
	localparam logic [7:0] R1_READY    = 8'h00;
	localparam logic [7:0] START_TOKEN = 8'hFE;
	localparam logic [7:0] BUSY_MASK   = 8'h80;
	localparam logic [5:0] CMD_GO_IDLE = 6'd0;
	localparam logic [5:0] CMD_IF_COND = 6'd8;
	localparam logic [5:0] CMD_READ    = 6'h11;

	typedef enum logic [1:0] {
		MODE_CMD  = 2'd0,
		MODE_READ = 2'd1,
		MODE_RX   = 2'd2
	} mode_t;

	typedef enum logic [1:0] {
		KIND_SEND   = 2'd0,
		KIND_DATA   = 2'd1,
		KIND_STATUS = 2'd2,
		KIND_DONE   = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_CMD_WAIT,
		PH_R1_WAIT,
		PH_TOKEN_WAIT,
		PH_DATA
	} phase_t;

	typedef enum logic [1:0] {
		RUN_FRAME,
		RUN_ONE,
		RUN_DATA_MID,
		RUN_DATA_END
	} run_t;

	typedef struct packed {
		run_t        run;
		kind_t       kind;
		logic [7:0]  value;
		logic [31:0] arg;
		logic [7:0]  crc;
		logic        sel;
		logic        tout;
	} desc_t;

endpackage

`default_nettype wire

// ===== src/sdcbr_if.sv =====
`default_nettype none

interface sdcbr_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  mode;
	logic [5:0]  command_index;
	logic [31:0] argument;
	logic [7:0]  received_byte;

	modport source (output valid, output mode, output command_index, output argument,
		output received_byte, input ready);
	modport sink (input valid, input mode, input command_index, input argument,
		input received_byte, output ready);
endinterface

interface sdcbr_rsp_if;
	logic       valid;
	logic       ready;
	logic [1:0] item_kind;
	logic [7:0] byte_value;
	logic       select_card;
	logic       response_timed_out;
	logic       last_of_run;

	modport source (output valid, output item_kind, output byte_value, output select_card,
		output response_timed_out, output last_of_run, input ready);
	modport sink (input valid, input item_kind, input byte_value, input select_card,
		input response_timed_out, input last_of_run, output ready);
endinterface

interface sdcbr_cfg_if;
	import sdcbr_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== src/sdcbr_front.sv =====
`default_nettype none

module sdcbr_front (
	input  wire logic              clk,
	input  wire logic              arst_n,
	sdcbr_req_if.sink              req,
	sdcbr_cfg_if.sink              cfg,
	input  wire logic              push_ready,
	output logic                   push_valid,
	output sdcbr_pkg::desc_t       push_desc
);
	import sdcbr_pkg::*;

	phase_t           phase_q, phase_d;
	logic [DC_W-1:0]  dc_q, dc_d;
	logic [8:0]       pc_q, pc_d;
	logic             sel_q, sel_d;
	logic             tout_q, tout_d;
	logic [8:0]       poll_lim_q;
	logic [7:0]       tok_lim_q;
	logic [8:0]       cmd_lim;
	logic [8:0]       tok_lim;
	logic             accept;

	assign req.ready = push_ready;
	assign cfg.ready = 1'b1;
	assign accept    = req.valid & push_ready;

	always_comb begin
		if (poll_lim_q == 9'd0) begin
			cmd_lim = 9'd1;
		end else if (poll_lim_q > POLL_LIMIT_MAX) begin
			cmd_lim = POLL_LIMIT_MAX;
		end else begin
			cmd_lim = poll_lim_q;
		end
		tok_lim = (tok_lim_q == 8'd0) ? 9'd1 : {1'b0, tok_lim_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			poll_lim_q <= POLL_LIMIT_RESET;
			tok_lim_q  <= TOKEN_LIMIT_RESET;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_POLL_LIMIT:  poll_lim_q <= cfg.data[8:0];
				REG_TOKEN_LIMIT: tok_lim_q  <= cfg.data[7:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			dc_q    <= '0;
			pc_q    <= '0;
			sel_q   <= 1'b0;
			tout_q  <= 1'b0;
		end else if (accept) begin
			phase_q <= phase_d;
			dc_q    <= dc_d;
			pc_q    <= pc_d;
			sel_q   <= sel_d;
			tout_q  <= tout_d;
		end
	end

	always_comb begin
		logic [8:0]      pc_inc;
		logic [DC_W-1:0] dc_inc;
		logic [7:0]      want;
		logic            hit;
		logic            spent;

		pc_inc = pc_q + 9'd1;
		dc_inc = dc_q + DC_W'(1);
		want   = (phase_q == PH_R1_WAIT) ? R1_READY : START_TOKEN;
		hit    = (req.received_byte == want);
		spent  = 1'b0;

		phase_d = phase_q;
		dc_d    = dc_q;
		pc_d    = pc_q;
		sel_d   = sel_q;
		tout_d  = tout_q;

		push_valid      = 1'b0;
		push_desc.run   = RUN_ONE;
		push_desc.kind  = KIND_SEND;
		push_desc.value = FILL_BYTE;
		push_desc.arg   = req.argument;
		push_desc.crc   = FILL_BYTE;
		push_desc.sel   = sel_q;
		push_desc.tout  = tout_q;

		case (req.mode)
			MODE_CMD, MODE_READ: begin
				sel_d   = 1'b1;
				tout_d  = 1'b0;
				pc_d    = '0;
				dc_d    = '0;
				push_valid     = accept;
				push_desc.run  = RUN_FRAME;
				push_desc.sel  = 1'b1;
				push_desc.tout = 1'b0;
				if (req.mode == MODE_CMD) begin
					phase_d         = PH_CMD_WAIT;
					push_desc.value = CMD_PREFIX | {2'b00, req.command_index};
					if (req.command_index == CMD_GO_IDLE) begin
						push_desc.crc = CRC_CMD0;
					end else if (req.command_index == CMD_IF_COND) begin
						push_desc.crc = CRC_CMD8;
					end
				end else begin
					phase_d         = PH_R1_WAIT;
					push_desc.value = CMD_PREFIX | {2'b00, CMD_READ};
				end
			end
			MODE_RX: begin
				case (phase_q)
					PH_CMD_WAIT: begin
						pc_d       = pc_inc;
						push_valid = accept;
						if ((req.received_byte & BUSY_MASK) == 8'h00) begin
							phase_d         = PH_IDLE;
							push_desc.kind  = KIND_STATUS;
							push_desc.value = req.received_byte;
						end else if (pc_inc >= cmd_lim) begin
							tout_d          = 1'b1;
							phase_d         = PH_IDLE;
							push_desc.kind  = KIND_STATUS;
							push_desc.value = req.received_byte;
							push_desc.tout  = 1'b1;
						end
					end
					PH_R1_WAIT, PH_TOKEN_WAIT: begin
						pc_d       = pc_inc;
						spent      = (pc_inc >= tok_lim);
						push_valid = accept;
						if (!hit && spent) begin
							tout_d         = 1'b1;
							push_desc.tout = 1'b1;
						end
						if (hit || spent) begin
							pc_d    = '0;
							dc_d    = '0;
							phase_d = (phase_q == PH_R1_WAIT) ? PH_TOKEN_WAIT : PH_DATA;
						end
					end
					PH_DATA: begin
						push_valid      = accept;
						push_desc.value = req.received_byte;
						if (dc_inc >= DC_W'(BLOCK_BYTES)) begin
							push_desc.run = RUN_DATA_END;
							sel_d         = 1'b0;
							phase_d       = PH_IDLE;
							dc_d          = '0;
						end else begin
							push_desc.run = RUN_DATA_MID;
							dc_d          = dc_inc;
						end
					end
					default: ;
				endcase
			end
			default: ;
		endcase
	end

endmodule

`default_nettype wire

// ===== src/sdcbr_queue.sv =====
`default_nettype none

module sdcbr_queue (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push_valid,
	input  wire sdcbr_pkg::desc_t  push_desc,
	output logic                   push_ready,
	output logic                   pop_valid,
	input  wire logic              pop,
	output sdcbr_pkg::desc_t       pop_desc
);
	import sdcbr_pkg::*;

	desc_t      slot_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] count_q;
	logic       do_push;
	logic       do_pop;

	assign push_ready = (count_q != 2'd2);
	assign pop_valid  = (count_q != 2'd0);
	assign pop_desc   = slot_q[rd_q];
	assign do_push    = push_valid & push_ready;
	assign do_pop     = pop & pop_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_q] <= push_desc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= 1'b0;
			rd_q    <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (do_push) begin
				wr_q <= ~wr_q;
			end
			if (do_pop) begin
				rd_q <= ~rd_q;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== src/sdcbr_back.sv =====
`default_nettype none

module sdcbr_back (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              head_valid,
	input  wire sdcbr_pkg::desc_t  head,
	output logic                   pop,
	sdcbr_rsp_if.source            rsp
);
	import sdcbr_pkg::*;

	logic [2:0] idx_q;
	logic       out_valid_q;
	kind_t      kind_q;
	logic [7:0] value_q;
	logic       sel_q;
	logic       tout_q;
	logic       last_q;
	logic       load;
	kind_t      kind_c;
	logic [7:0] value_c;
	logic       sel_c;
	logic       last_c;

	assign load = head_valid & (~out_valid_q | rsp.ready);
	assign pop  = load & last_c;

	always_comb begin
		kind_c  = KIND_SEND;
		value_c = FILL_BYTE;
		sel_c   = head.sel;
		last_c  = 1'b0;
		case (head.run)
			RUN_FRAME: begin
				case (idx_q)
					3'd0:    value_c = head.value;
					3'd1:    value_c = head.arg[31:24];
					3'd2:    value_c = head.arg[23:16];
					3'd3:    value_c = head.arg[15:8];
					3'd4:    value_c = head.arg[7:0];
					3'd5:    value_c = head.crc;
					default: last_c  = 1'b1;
				endcase
			end
			RUN_ONE: begin
				kind_c  = head.kind;
				value_c = head.value;
				last_c  = 1'b1;
			end
			RUN_DATA_MID: begin
				if (idx_q == 3'd0) begin
					kind_c  = KIND_DATA;
					value_c = head.value;
				end else begin
					last_c = 1'b1;
				end
			end
			default: begin
				case (idx_q)
					3'd0: begin
						kind_c  = KIND_DATA;
						value_c = head.value;
					end
					3'd1, 3'd2: ;
					default: begin
						kind_c  = KIND_DONE;
						value_c = 8'h00;
						sel_c   = 1'b0;
						last_c  = 1'b1;
					end
				endcase
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= 3'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				idx_q       <= last_c ? 3'd0 : idx_q + 3'd1;
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			kind_q  <= kind_c;
			value_q <= value_c;
			sel_q   <= sel_c;
			tout_q  <= head.tout;
			last_q  <= last_c;
		end
	end

	assign rsp.valid              = out_valid_q;
	assign rsp.item_kind          = kind_q;
	assign rsp.byte_value         = value_q;
	assign rsp.select_card        = sel_q;
	assign rsp.response_timed_out = tout_q;
	assign rsp.last_of_run        = last_q;

endmodule

`default_nettype wire

// ===== src/sd_spi_command_block_read.sv =====
// SPI-side sequencer for an SD card: command frames and single block reads.
// The req channel carries one request per SPI byte event: start a command,
// start a block read, or hand back the byte received during the last send.
// The rsp channel returns result items in order: bytes to send, data bytes,
// the command status and a read-finished marker, with last_of_run set on the
// final item caused by each request. The cfg channel writes the two poll
// limits and is always ready; the user must write it only while the block
// is idle, as the block itself does not enforce this. An accepted request
// is written into the queue and its results leave from the output register.
// The front part takes one request per cycle while its two-entry queue has
// room; the back part sends one result per cycle while the receiver is ready.
// A start request yields seven result items, a data byte two and the last
// data byte four. When the receiver stalls, the output register holds its
// item, the queue fills and req.ready falls. Reset clears the sequencer to
// idle, deselects the card and sets 256 response polls and 10 token polls.
`default_nettype none

module sd_spi_command_block_read (
	input  wire logic   clk,
	input  wire logic   arst_n,
	sdcbr_req_if.sink   req,
	sdcbr_rsp_if.source rsp,
	sdcbr_cfg_if.sink   cfg
);
	import sdcbr_pkg::*;

	logic  push_valid;
	logic  push_ready;
	desc_t push_desc;
	logic  head_valid;
	desc_t head;
	logic  pop;

	sdcbr_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.cfg        (cfg),
		.push_ready (push_ready),
		.push_valid (push_valid),
		.push_desc  (push_desc)
	);

	sdcbr_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_desc  (push_desc),
		.push_ready (push_ready),
		.pop_valid  (head_valid),
		.pop        (pop),
		.pop_desc   (head)
	);

	sdcbr_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.rsp        (rsp)
	);

endmodule

`default_nettype wire

// ===== tb/sdcbr_result_checker.sv =====
module sdcbr_result_checker
	import sdcbr_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	sdcbr_req_if  req,
	sdcbr_rsp_if  rsp,
	sdcbr_cfg_if  cfg,
	output int    fail_count,
	output int    pending,
	output int    live_items,
	output int    checked_items,
	output int    timeout_ops
);

	typedef struct packed {
		kind_t      kind;
		logic [7:0] value;
		logic       sel;
		logic       tout;
		logic       last;
	} card_item_t;

	card_item_t awaited_items[$];
	card_item_t step_buf[0:6];
	int         step_n;

	logic [8:0]  poll_limit;
	logic [7:0]  token_limit;
	phase_t      phase;
	logic [10:0] data_count;
	logic [8:0]  poll_count;
	logic        selected;
	logic        timed_out;

	int fail_n;
	int live_n;
	int checked_n;
	int timeout_n;

	function automatic void put_item(kind_t kind, logic [7:0] value);
		step_buf[step_n] = '{kind: kind, value: value, sel: selected, tout: timed_out,
			last: 1'b0};
		step_n++;
	endfunction

	function automatic void put_frame(logic [7:0] head, logic [31:0] arg, logic [7:0] crc);
		put_item(KIND_SEND, head);
		put_item(KIND_SEND, arg[31:24]);
		put_item(KIND_SEND, arg[23:16]);
		put_item(KIND_SEND, arg[15:8]);
		put_item(KIND_SEND, arg[7:0]);
		put_item(KIND_SEND, crc);
		put_item(KIND_SEND, FILL_BYTE);
	endfunction

	function automatic logic [8:0] response_polls();
		if (poll_limit == 9'd0) return 9'd1;
		if (poll_limit > POLL_LIMIT_MAX) return POLL_LIMIT_MAX;
		return poll_limit;
	endfunction

	function automatic logic [8:0] token_polls();
		return (token_limit == 8'd0) ? 9'd1 : {1'b0, token_limit};
	endfunction

	function automatic void start_operation(phase_t next);
		selected   = 1'b1;
		timed_out  = 1'b0;
		poll_count = '0;
		data_count = '0;
		phase      = next;
	endfunction

	task automatic advance_sequencer(logic [1:0] mode, logic [5:0] cmd, logic [31:0] arg,
		logic [7:0] rx);
		logic [7:0] crc;
		logic [7:0] want;
		step_n = 0;
		if (mode == MODE_CMD) begin
			crc = FILL_BYTE;
			if (cmd == CMD_GO_IDLE) crc = CRC_CMD0;
			if (cmd == CMD_IF_COND) crc = CRC_CMD8;
			start_operation(PH_CMD_WAIT);
			put_frame({2'b00, cmd} | CMD_PREFIX, arg, crc);
		end else if (mode == MODE_READ) begin
			start_operation(PH_R1_WAIT);
			put_frame({2'b00, CMD_READ} | CMD_PREFIX, arg, FILL_BYTE);
		end else if (mode == MODE_RX) begin
			case (phase)
				PH_CMD_WAIT: begin
					poll_count = poll_count + 9'd1;
					if ((rx & BUSY_MASK) == 8'h00) begin
						phase = PH_IDLE;
						put_item(KIND_STATUS, rx);
					end else if (poll_count >= response_polls()) begin
						timed_out = 1'b1;
						phase     = PH_IDLE;
						put_item(KIND_STATUS, rx);
					end else begin
						put_item(KIND_SEND, FILL_BYTE);
					end
				end
				PH_R1_WAIT, PH_TOKEN_WAIT: begin
					want = (phase == PH_R1_WAIT) ? R1_READY : START_TOKEN;
					poll_count = poll_count + 9'd1;
					if (rx != want && poll_count >= token_polls()) timed_out = 1'b1;
					if (rx == want || poll_count >= token_polls()) begin
						poll_count = '0;
						data_count = '0;
						phase = (phase == PH_R1_WAIT) ? PH_TOKEN_WAIT : PH_DATA;
					end
					put_item(KIND_SEND, FILL_BYTE);
				end
				PH_DATA: begin
					put_item(KIND_DATA, rx);
					data_count = data_count + 11'd1;
					if (data_count >= BLOCK_BYTES) begin
						put_item(KIND_SEND, FILL_BYTE);
						put_item(KIND_SEND, FILL_BYTE);
						selected   = 1'b0;
						phase      = PH_IDLE;
						data_count = '0;
						put_item(KIND_DONE, 8'h00);
					end else begin
						put_item(KIND_SEND, FILL_BYTE);
					end
				end
				default: begin
				end
			endcase
		end
		if (step_n > 0) begin
			step_buf[step_n - 1].last = 1'b1;
			live_n++;
		end
		for (int i = 0; i < step_n; i++) awaited_items.push_back(step_buf[i]);
	endtask

	task automatic check_result();
		card_item_t want;
		card_item_t got;
		got = '{kind: kind_t'(rsp.item_kind), value: rsp.byte_value, sel: rsp.select_card,
			tout: rsp.response_timed_out, last: rsp.last_of_run};
		checked_n++;
		if (awaited_items.size() == 0) begin
			fail_n++;
			if (fail_n <= 10)
				$display("result %0d: no result expected, got kind=%0d byte=%02h sel=%b tout=%b last=%b",
					checked_n, got.kind, got.value, got.sel, got.tout, got.last);
		end else begin
			want = awaited_items.pop_front();
			if (got !== want) begin
				fail_n++;
				if (fail_n <= 10)
					$display("result %0d: expected kind=%0d byte=%02h sel=%b tout=%b last=%b, got kind=%0d byte=%02h sel=%b tout=%b last=%b",
						checked_n, want.kind, want.value, want.sel, want.tout, want.last,
						got.kind, got.value, got.sel, got.tout, got.last);
			end else if (want.last && want.tout &&
				(want.kind == KIND_STATUS || want.kind == KIND_DONE)) begin
				timeout_n++;
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			poll_limit  = POLL_LIMIT_RESET;
			token_limit = TOKEN_LIMIT_RESET;
			phase       = PH_IDLE;
			data_count  = '0;
			poll_count  = '0;
			selected    = 1'b0;
			timed_out   = 1'b0;
			awaited_items.delete();
			fail_n      = 0;
			live_n      = 0;
			checked_n   = 0;
			timeout_n   = 0;
		end else begin
			if (rsp.valid && rsp.ready) check_result();
			if (cfg.valid && cfg.ready) begin
				if (cfg.index == REG_POLL_LIMIT) poll_limit = cfg.data;
				else if (cfg.index == REG_TOKEN_LIMIT) token_limit = cfg.data[7:0];
			end
			if (req.valid && req.ready)
				advance_sequencer(req.mode, req.command_index, req.argument, req.received_byte);
		end
		fail_count    <= fail_n;
		pending       <= awaited_items.size();
		live_items    <= live_n;
		checked_items <= checked_n;
		timeout_ops   <= timeout_n;
	end

endmodule

// ===== tb/tb_sd_spi_command_block_read.sv =====
module tb_sd_spi_command_block_read;
	import sdcbr_pkg::*;

	localparam int CYCLE_LIMIT   = 100000;
	localparam int SETTLE_CYCLES = 8;
	localparam int HOLD_CYCLES   = 400;
	localparam int PHASE_ITEMS   = 16;

	localparam logic [1:0]           MODE_UNUSED  = 2'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = CFG_IDX_W'(3);

	logic clk;
	logic arst_n;

	int cycles = 0;
	int fail_count;
	int pending;
	int live_items;
	int checked_items;
	int timeout_ops;

	int rsp_gap   = 0;
	int hold_left = 0;
	bit hold_req  = 1'b0;
	bit no_idle   = 1'b0;

	int poll_eff;
	int tok_eff;
	int cmd_starts  = 0;
	int read_starts = 0;
	int full_reads  = 0;

	sdcbr_req_if req_ch();
	sdcbr_rsp_if rsp_ch();
	sdcbr_cfg_if cfg_ch();

	sd_spi_command_block_read dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch),
		.cfg    (cfg_ch)
	);

	sdcbr_result_checker result_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.req           (req_ch),
		.rsp           (rsp_ch),
		.cfg           (cfg_ch),
		.fail_count    (fail_count),
		.pending       (pending),
		.live_items    (live_items),
		.checked_items (checked_items),
		.timeout_ops   (timeout_ops)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (hold_req) begin
			hold_req  = 1'b0;
			hold_left = HOLD_CYCLES;
		end else if (hold_left > 0) begin
			hold_left--;
		end
		if (rsp_ch.valid && rsp_ch.ready) rsp_gap = no_idle ? 0 : int'($urandom_range(0, 8));
		else if (rsp_gap > 0) rsp_gap--;
	end

	always @(negedge clk) rsp_ch.ready <= (hold_left == 0 && rsp_gap == 0);

	task automatic offer(logic [1:0] mode, logic [5:0] cmd, logic [31:0] arg, logic [7:0] rx);
		int gap;
		gap = no_idle ? 0 : int'($urandom_range(0, 8));
		@(negedge clk);
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_ch.valid         <= 1'b1;
		req_ch.mode          <= mode;
		req_ch.command_index <= cmd;
		req_ch.argument      <= arg;
		req_ch.received_byte <= rx;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
	endtask

	task automatic offer_byte(logic [7:0] rx);
		offer(MODE_RX, 6'($urandom), 32'($urandom), rx);
	endtask

	task automatic await_all_results();
		@(negedge clk);
		req_ch.valid <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
		@(negedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= value;
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic set_limits(logic [8:0] poll, logic [7:0] tok);
		logic high_bit;
		high_bit = 1'($urandom_range(0, 1));
		write_reg(REG_POLL_LIMIT, poll);
		write_reg(REG_TOKEN_LIMIT, {high_bit, tok});
		poll_eff = (poll == 9'd0) ? 1 :
			((poll > POLL_LIMIT_MAX) ? int'(POLL_LIMIT_MAX) : int'(poll));
		tok_eff  = (tok == 8'd0) ? 1 : int'(tok);
	endtask

	function automatic int wait_polls(int limit);
		if (limit <= 20 && $urandom_range(0, 3) == 0)
			return int'($urandom_range((limit > 1) ? limit - 1 : 0, limit + 1));
		return int'($urandom_range(0, 2));
	endfunction

	task automatic run_command(logic [5:0] cmd, logic [31:0] arg, int polls, bit answer);
		offer(MODE_CMD, cmd, arg, 8'($urandom));
		cmd_starts++;
		repeat (polls) offer_byte(8'($urandom_range(128, 255)));
		if (answer) offer_byte(8'($urandom_range(0, 127)));
	endtask

	task automatic run_read(logic [31:0] arg, int r1_noise, int tok_noise, int nbytes);
		offer(MODE_READ, 6'($urandom), arg, 8'($urandom));
		read_starts++;
		repeat (r1_noise) offer_byte(8'($urandom_range(1, 255)));
		offer_byte(R1_READY);
		repeat (tok_noise)
			offer_byte($urandom_range(0, 1) ? FILL_BYTE : 8'($urandom_range(0, 253)));
		offer_byte(START_TOKEN);
		repeat (nbytes) offer_byte(8'($urandom));
		if (nbytes >= BLOCK_BYTES) full_reads++;
	endtask

	task automatic random_sequence();
		int         pick;
		logic [5:0] cmd;
		pick = int'($urandom_range(0, 11));
		if (pick < 5) begin
			cmd = 6'($urandom);
			if (pick == 0) cmd = CMD_GO_IDLE;
			if (pick == 1) cmd = CMD_IF_COND;
			if (pick == 2) cmd = CMD_READ;
			run_command(cmd, 32'($urandom), wait_polls(poll_eff), $urandom_range(0, 7) != 0);
		end else if (pick < 10) begin
			run_read(32'($urandom), wait_polls(tok_eff), wait_polls(tok_eff),
				int'($urandom_range(0, 24)));
		end else if (pick == 10) begin
			offer(MODE_UNUSED, 6'($urandom), 32'($urandom), 8'($urandom));
		end else begin
			repeat ($urandom_range(1, 3)) offer_byte(8'($urandom));
		end
		if ($urandom_range(0, 15) == 0) await_all_results();
	endtask

	task automatic run_phase(logic [8:0] poll, logic [7:0] tok, bit full, bit hold, bit burst);
		int goal;
		set_limits(poll, tok);
		no_idle = burst;
		if (hold) hold_req = 1'b1;
		goal = live_items + PHASE_ITEMS;
		if (full) run_read(32'($urandom), 0, int'($urandom_range(0, 2)), BLOCK_BYTES);
		while (live_items < goal) random_sequence();
		await_all_results();
		no_idle = 1'b0;
	endtask

	initial begin
		req_ch.valid         = 1'b0;
		req_ch.mode          = MODE_RX;
		req_ch.command_index = '0;
		req_ch.argument      = '0;
		req_ch.received_byte = '0;
		cfg_ch.valid         = 1'b0;
		cfg_ch.index         = '0;
		cfg_ch.data          = '0;
		rsp_ch.ready         = 1'b0;
		arst_n               = 1'b0;
		poll_eff             = int'(POLL_LIMIT_RESET);
		tok_eff              = int'(TOKEN_LIMIT_RESET);
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		offer_byte(R1_READY);
		offer(MODE_UNUSED, 6'h3F, 32'hFFFF_FFFF, FILL_BYTE);
		offer(MODE_CMD, CMD_GO_IDLE, 32'h0000_0000, 8'h00);
		offer_byte(FILL_BYTE);
		offer_byte(8'h01);
		offer(MODE_CMD, CMD_IF_COND, 32'h0000_01AA, 8'hFF);
		offer_byte(8'h00);
		offer(MODE_CMD, 6'h3F, 32'hFFFF_FFFF, 8'h00);
		offer_byte(8'h80);
		offer_byte(8'h7F);
		offer(MODE_READ, 6'h00, 32'hFFFF_FFFF, 8'hFF);
		offer_byte(R1_READY);
		offer_byte(START_TOKEN);
		offer_byte(8'hA5);
		offer(MODE_CMD, CMD_READ, 32'h1234_5678, 8'h00);
		offer_byte(FILL_BYTE);
		offer(MODE_READ, 6'h2A, 32'h0000_0000, 8'h00);
		offer_byte(R1_READY);
		offer_byte(START_TOKEN);
		offer_byte(8'h5A);
		cmd_starts  += 4;
		read_starts += 2;
		await_all_results();

		run_phase(9'd1, 8'd1, 1'b0, 1'b0, 1'b0);
		write_reg(REG_SPARE_LO, CFG_DATA_W'($urandom));
		write_reg(REG_SPARE_HI, CFG_DATA_W'($urandom));
		run_phase(9'd0, 8'd0, 1'b0, 1'b0, 1'b0);
		run_phase(9'd256, 8'd255, 1'b1, 1'b0, 1'b1);
		run_phase(9'd511, 8'd10, 1'b0, 1'b1, 1'b0);
		run_phase(9'($urandom_range(1, 300)), 8'($urandom_range(1, 20)), 1'b0, 1'b0, 1'b0);
		run_phase(9'($urandom_range(1, 8)), 8'($urandom_range(1, 4)), 1'b0, 1'b0, 1'b0);
		await_all_results();

		$display("Run covered %0d result-producing requests: %0d commands, %0d block reads,",
			live_items, cmd_starts, read_starts);
		$display("%0d read to the end; %0d result items compared, %0d ended on an expired wait.",
			full_reads, checked_items, timeout_ops);
		if (fail_count == 0 && pending == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
